// ===== hdl/iso8583_message_parser_macros.svh =====
// Assertion macros for the message parser.
// ISO_ASSERT checks under reset gating; ISO_ASSERT_NR also checks while in reset.
`ifndef ISO8583_MESSAGE_PARSER_MACROS_SVH
`define ISO8583_MESSAGE_PARSER_MACROS_SVH

`ifndef SYNTH
`define ISO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iso8583 parser check failed");
`define ISO_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("iso8583 parser reset check failed");
`else
`define ISO_ASSERT(lbl, prop)
`define ISO_ASSERT_NR(lbl, prop)
`endif

`endif

// ===== hdl/iso8583_pkg.sv =====
package iso8583_pkg;

  localparam int TPDU_BYTES     = 5;
  localparam int MTI_BYTES      = 4;
  localparam int BITMAP_BYTES   = 8;
  localparam int FIELD_CAPACITY = 1024;
  localparam int ELEM_SKIP      = 65;
  localparam int ELEM_LAST      = 128;
  localparam int HDR_CNT_W      = 4;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [1:0] DIG_FIXED = 2'd0;
  localparam logic [1:0] DIG_LL    = 2'd2;
  localparam logic [1:0] DIG_LLL   = 2'd3;

  typedef enum logic [2:0] {
    PH_START,
    PH_TPDU,
    PH_MTI,
    PH_PRI,
    PH_SEC,
    PH_PREFIX,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIELD,
    KIND_EMPTY,
    KIND_STATUS,
    KIND_HEADER
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FORMAT,
    ST_FIELD
  } stat_t;

  typedef enum logic [1:0] {
    PE_NONE,
    PE_FORMAT,
    PE_FIELD,
    PE_OVERCAP
  } perr_t;

  typedef struct packed {
    logic       binary;
    logic [1:0] digits;
    logic [9:0] max_len;
  } elem_info_t;

  typedef struct packed {
    kind_t      item_kind;
    logic [7:0] element_number;
    logic [7:0] out_byte;
    logic [9:0] byte_offset;
    logic       field_end;
    logic       binary_field;
    stat_t      status_code;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Data element format table, indexed by element number.
  function automatic elem_info_t elem_info(input logic [7:0] e);
    elem_info_t r;
    r = '0;
    case (e)
      8'd27, 8'd66, 8'd91: r = '{1'b0, DIG_FIXED, 10'd1};
      8'd25, 8'd26, 8'd39, 8'd67, 8'd92: r = '{1'b0, DIG_FIXED, 10'd2};
      8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd40, 8'd49, 8'd50, 8'd51,
      8'd68, 8'd69, 8'd70: r = '{1'b0, DIG_FIXED, 10'd3};
      8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd71, 8'd72:
        r = '{1'b0, DIG_FIXED, 10'd4};
      8'd93: r = '{1'b0, DIG_FIXED, 10'd5};
      8'd3, 8'd11, 8'd12, 8'd38, 8'd73: r = '{1'b0, DIG_FIXED, 10'd6};
      8'd94: r = '{1'b0, DIG_FIXED, 10'd7};
      8'd8, 8'd9, 8'd10, 8'd41: r = '{1'b0, DIG_FIXED, 10'd8};
      8'd28, 8'd29, 8'd30, 8'd31: r = '{1'b0, DIG_FIXED, 10'd9};
      8'd7, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81:
        r = '{1'b0, DIG_FIXED, 10'd10};
      8'd4, 8'd5, 8'd6, 8'd37, 8'd82, 8'd83, 8'd84, 8'd85:
        r = '{1'b0, DIG_FIXED, 10'd12};
      8'd42: r = '{1'b0, DIG_FIXED, 10'd15};
      8'd53, 8'd86, 8'd87, 8'd88, 8'd89: r = '{1'b0, DIG_FIXED, 10'd16};
      8'd97: r = '{1'b0, DIG_FIXED, 10'd17};
      8'd98: r = '{1'b0, DIG_FIXED, 10'd25};
      8'd43: r = '{1'b0, DIG_FIXED, 10'd40};
      8'd90, 8'd95: r = '{1'b0, DIG_FIXED, 10'd42};
      8'd52, 8'd64, 8'd96, 8'd128: r = '{1'b1, DIG_FIXED, 10'd8};
      8'd32, 8'd33, 8'd99, 8'd100: r = '{1'b0, DIG_LL, 10'd11};
      8'd101: r = '{1'b0, DIG_LL, 10'd17};
      8'd2: r = '{1'b0, DIG_LL, 10'd19};
      8'd34, 8'd102, 8'd103: r = '{1'b0, DIG_LL, 10'd28};
      8'd35: r = '{1'b0, DIG_LL, 10'd37};
      8'd45: r = '{1'b0, DIG_LL, 10'd76};
      8'd44: r = '{1'b0, DIG_LL, 10'd99};
      8'd56: r = '{1'b0, DIG_LLL, 10'd35};
      8'd104: r = '{1'b0, DIG_LLL, 10'd100};
      8'd36: r = '{1'b0, DIG_LLL, 10'd104};
      8'd54: r = '{1'b0, DIG_LLL, 10'd120};
      8'd55: r = '{1'b1, DIG_LLL, 10'd255};
      8'd46, 8'd47, 8'd48, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63:
        r = '{1'b0, DIG_LLL, 10'd999};
      default: begin
        if (e >= 8'd105 && e <= 8'd127) begin
          r = '{1'b0, DIG_LLL, 10'd999};
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/iso8583_in_if.sv =====
interface iso8583_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== hdl/iso8583_out_if.sv =====
interface iso8583_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] element_number;
  logic [7:0] out_byte;
  logic [9:0] byte_offset;
  logic       field_end;
  logic       binary_field;
  logic [1:0] status_code;
  logic       last_of_run;

  modport source (
    output valid, output item_kind, output element_number, output out_byte,
    output byte_offset, output field_end, output binary_field, output status_code,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input item_kind, input element_number, input out_byte,
    input byte_offset, input field_end, input binary_field, input status_code,
    input last_of_run, output ready
  );
endinterface

// ===== hdl/iso8583_fifo.sv =====
module iso8583_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  iso8583_pkg::push_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output iso8583_pkg::res_t   head
);
  import iso8583_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  res_t             mem_r [FIFO_DEPTH];
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // Leave space for a two-result transfer without looking at this cycle's pop.
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push.r1;
    end
  end

endmodule

// ===== hdl/iso8583_step.sv =====
module iso8583_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tpdu_present,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_eom,
  input  logic               room,
  output iso8583_pkg::push_t push
);
  import iso8583_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       eom_r;

  // parse state
  phase_t               phase_r, phase_nxt, ph_eff, ph_s;
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt, hc_s;
  logic [127:0]         bitmap_r, bitmap_nxt, bm_s, bm_wr;
  logic [7:0]           elem_r, elem_nxt, el_s;
  logic [9:0]           pfx_val_r, pfx_val_nxt, pv_s;
  logic [1:0]           pfx_left_r, pfx_left_nxt, pl_s;
  logic [9:0]           bytes_left_r, bytes_left_nxt, bl_s;
  logic [9:0]           fld_off_r, fld_off_nxt, fo_s;
  perr_t                perr_r, perr_nxt, pe_s;
  logic                 done_r, done_nxt, dn_s;

  logic       step_fire;
  logic       consume;
  logic [4:0] hdr_size;
  logic       hdr_end;
  logic       is_digit;
  logic [3:0] digit;
  logic [12:0] pv_mul;
  logic [9:0] pv_calc;
  logic [1:0] pl_dec;
  logic [3:0] bm_slot;
  elem_info_t cur_info;
  elem_info_t adv_info;
  logic [7:0] adv_from;
  logic [127:0] cand;
  logic       adv_found;
  logic [7:0] adv_el;
  logic       do_adv;
  logic       do_start;
  logic [9:0] start_len;
  logic       hit;
  res_t       res_c;
  res_t       res_st;

  assign step_fire = in_valid_r && room;
  assign in_ready  = !in_valid_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      eom_r  <= in_eom;
    end
  end

  // At the first byte of a message, tpdu_present picks the header layout.
  always_comb begin
    if (phase_r == PH_START) begin
      ph_eff = tpdu_present ? PH_TPDU : PH_MTI;
    end else begin
      ph_eff = phase_r;
    end
  end

  assign consume = !done_r && (perr_r == PE_NONE || perr_r == PE_OVERCAP);

  always_comb begin
    case (ph_eff)
      PH_TPDU: hdr_size = 5'(TPDU_BYTES);
      PH_MTI:  hdr_size = 5'(MTI_BYTES);
      default: hdr_size = 5'(BITMAP_BYTES);
    endcase
  end

  assign hdr_end  = (5'(hdr_cnt_r) + 5'd1) >= hdr_size;
  assign is_digit = (byte_r >= 8'h30) && (byte_r <= 8'h39);
  assign digit    = 4'(byte_r - 8'h30);
  assign pv_mul   = {pfx_val_r, 3'b000} + {2'b00, pfx_val_r, 1'b0} + {9'b0, digit};
  assign pv_calc  = pv_mul[9:0];
  assign pl_dec   = pfx_left_r - 2'd1;
  assign cur_info = elem_info(elem_r);

  // Bitmap byte lands MSB first: bit 7 of a byte is the lowest element.
  assign bm_slot = {(ph_eff == PH_SEC), hdr_cnt_r[2:0]};
  always_comb begin
    bm_wr = bitmap_r;
    if (ph_eff == PH_PRI || ph_eff == PH_SEC) begin
      for (int j = 0; j < 8; j++) begin
        bm_wr[{bm_slot, 3'(7 - j)}] = byte_r[j];
      end
    end
  end

  // Next present element after adv_from, skipping element 65, by priority encode over the bitmap.
  assign adv_from = (ph_eff == PH_PRI || ph_eff == PH_SEC) ? 8'd1 : elem_r;
  always_comb begin
    cand = '0;
    for (int e = 2; e <= ELEM_LAST; e++) begin
      cand[e-1] = bm_wr[e-1] && (8'(e) > adv_from) && (e != ELEM_SKIP);
    end
  end

  always_comb begin
    adv_found = 1'b0;
    adv_el    = 8'(ELEM_LAST);
    for (int e = ELEM_LAST; e >= 2; e--) begin
      if (cand[e-1]) begin
        adv_found = 1'b1;
        adv_el    = 8'(e);
      end
    end
  end

  assign adv_info = elem_info(adv_el);

  // parse state step
  always_comb begin
    ph_s = ph_eff;
    hc_s = hdr_cnt_r;
    bm_s = bitmap_r;
    el_s = elem_r;
    pv_s = pfx_val_r;
    pl_s = pfx_left_r;
    bl_s = bytes_left_r;
    fo_s = fld_off_r;
    pe_s = perr_r;
    dn_s = done_r;
    do_adv    = 1'b0;
    do_start  = 1'b0;
    start_len = '0;
    if (consume) begin
      bm_s = bm_wr;
      case (ph_eff)
        PH_TPDU, PH_MTI, PH_PRI, PH_SEC: begin
          hc_s = hdr_end ? '0 : hdr_cnt_r + HDR_CNT_W'(1);
          if (hdr_end) begin
            case (ph_eff)
              PH_TPDU: ph_s = PH_MTI;
              PH_MTI:  ph_s = PH_PRI;
              PH_PRI: begin
                if (bm_wr[0]) begin
                  ph_s = PH_SEC;
                end else begin
                  do_adv = 1'b1;
                end
              end
              default: do_adv = 1'b1;
            endcase
          end
        end
        PH_PREFIX: begin
          if (!is_digit) begin
            pe_s = PE_FORMAT;
          end else begin
            pv_s = pv_calc;
            pl_s = pl_dec;
            if (pl_dec == 2'd0) begin
              if (pv_calc > cur_info.max_len) begin
                pe_s = PE_FIELD;
              end else if (pv_calc == 10'd0) begin
                do_adv = 1'b1;
              end else begin
                do_start  = 1'b1;
                start_len = pv_calc;
              end
            end
          end
        end
        PH_DATA: begin
          if (bytes_left_r == 10'd0) begin
            do_adv = 1'b1;
          end else if (perr_r == PE_OVERCAP) begin
            bl_s = bytes_left_r - 10'd1;
            if (bytes_left_r == 10'd1) begin
              pe_s = PE_FIELD;
            end
          end else begin
            fo_s = fld_off_r + 10'd1;
            bl_s = bytes_left_r - 10'd1;
            if (bytes_left_r == 10'd1) begin
              do_adv = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_adv) begin
      if (adv_found) begin
        el_s = adv_el;
        if (adv_info.digits != DIG_FIXED) begin
          pl_s = adv_info.digits;
          pv_s = '0;
          ph_s = PH_PREFIX;
        end else begin
          do_start  = 1'b1;
          start_len = adv_info.max_len;
        end
      end else begin
        el_s = 8'(ELEM_LAST);
        dn_s = 1'b1;
        ph_s = PH_DONE;
      end
    end
    if (do_start) begin
      bl_s = start_len;
      fo_s = '0;
      ph_s = PH_DATA;
      if ({1'b0, start_len} > 11'(FIELD_CAPACITY - 1)) begin
        pe_s = PE_OVERCAP;
      end
    end
  end

  // End of message: return to message start with everything cleared.
  always_comb begin
    if (eom_r) begin
      phase_nxt      = PH_START;
      hdr_cnt_nxt    = '0;
      bitmap_nxt     = '0;
      elem_nxt       = '0;
      pfx_val_nxt    = '0;
      pfx_left_nxt   = '0;
      bytes_left_nxt = '0;
      fld_off_nxt    = '0;
      perr_nxt       = PE_NONE;
      done_nxt       = 1'b0;
    end else begin
      phase_nxt      = ph_s;
      hdr_cnt_nxt    = hc_s;
      bitmap_nxt     = bm_s;
      elem_nxt       = el_s;
      pfx_val_nxt    = pv_s;
      pfx_left_nxt   = pl_s;
      bytes_left_nxt = bl_s;
      fld_off_nxt    = fo_s;
      perr_nxt       = pe_s;
      done_nxt       = dn_s;
    end
  end

  // result outputs
  always_comb begin
    hit   = 1'b0;
    res_c = '0;
    if (consume) begin
      case (ph_eff)
        PH_TPDU, PH_MTI, PH_PRI, PH_SEC: begin
          hit                = 1'b1;
          res_c.item_kind    = KIND_HEADER;
          res_c.out_byte     = byte_r;
          res_c.byte_offset  = 10'(hdr_cnt_r);
          res_c.field_end    = hdr_end;
          res_c.binary_field = (ph_eff != PH_MTI);
        end
        PH_PREFIX: begin
          if (is_digit && pl_dec == 2'd0 && pv_calc == 10'd0) begin
            hit                  = 1'b1;
            res_c.item_kind      = KIND_EMPTY;
            res_c.element_number = elem_r;
            res_c.field_end      = 1'b1;
            res_c.binary_field   = cur_info.binary;
          end
        end
        PH_DATA: begin
          if (bytes_left_r != 10'd0 && perr_r != PE_OVERCAP) begin
            hit                  = 1'b1;
            res_c.item_kind      = KIND_FIELD;
            res_c.element_number = elem_r;
            res_c.out_byte       = byte_r;
            res_c.byte_offset    = fld_off_r;
            res_c.field_end      = (bytes_left_r == 10'd1);
            res_c.binary_field   = cur_info.binary;
          end
        end
        default: ;
      endcase
    end
    res_st           = '0;
    res_st.item_kind = KIND_STATUS;
    if (pe_s == PE_FIELD) begin
      res_st.status_code = ST_FIELD;
    end else if (pe_s != PE_NONE) begin
      res_st.status_code = ST_FORMAT;
    end else begin
      res_st.status_code = dn_s ? ST_OK : ST_FORMAT;
    end
    res_st.last_of_run = 1'b1;
    res_c.last_of_run  = !eom_r;
  end

  always_comb begin
    push.cnt = '0;
    push.r0  = hit ? res_c : res_st;
    push.r1  = res_st;
    if (step_fire) begin
      push.cnt = {1'b0, hit} + {1'b0, eom_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      hdr_cnt_r    <= '0;
      bitmap_r     <= '0;
      elem_r       <= '0;
      pfx_val_r    <= '0;
      pfx_left_r   <= '0;
      bytes_left_r <= '0;
      fld_off_r    <= '0;
      perr_r       <= PE_NONE;
      done_r       <= 1'b0;
    end else if (step_fire) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      bitmap_r     <= bitmap_nxt;
      elem_r       <= elem_nxt;
      pfx_val_r    <= pfx_val_nxt;
      pfx_left_r   <= pfx_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      fld_off_r    <= fld_off_nxt;
      perr_r       <= perr_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule

// ===== hdl/iso8583_message_parser.sv =====
// A byte accepted on in_chan passes the input register, then the result queue,
//   before its first result shows on out_chan.
// Throughput: one byte per cycle while the queue has room; a byte yields at most one
//   result, plus a status at message end; 4-entry queue drains one per cycle on ready.
// Reset: synchronous, active low; clears parse state, tpdu_present and the queue.
`include "iso8583_message_parser_macros.svh"

module iso8583_message_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  iso8583_in_if.sink        in_chan,
  iso8583_out_if.source     out_chan
);
  import iso8583_pkg::*;

  logic  tpdu_present_r;
  push_t step_push;
  logic  fifo_room;
  res_t  head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpdu_present_r <= 1'b0;
    end else if (cfg_wr_en) begin
      tpdu_present_r <= cfg_wr_data;
    end
  end

  iso8583_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .tpdu_present (tpdu_present_r),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_byte      (in_chan.in_byte),
    .in_eom       (in_chan.end_of_message),
    .room         (fifo_room),
    .push         (step_push)
  );

  iso8583_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_push),
    .room      (fifo_room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .head      (head)
  );

  assign out_chan.item_kind      = head.item_kind;
  assign out_chan.element_number = head.element_number;
  assign out_chan.out_byte       = head.out_byte;
  assign out_chan.byte_offset    = head.byte_offset;
  assign out_chan.field_end      = head.field_end;
  assign out_chan.binary_field   = head.binary_field;
  assign out_chan.status_code    = head.status_code;
  assign out_chan.last_of_run    = head.last_of_run;

  `ISO_ASSERT(a_push_has_room, step_push.cnt != 2'd0 |-> fifo_room)
  `ISO_ASSERT(a_pair_ends_status, step_push.cnt == 2'd2 |->
    step_push.r1.item_kind == KIND_STATUS && !step_push.r0.last_of_run)
  `ISO_ASSERT(a_status_only_on_status, out_chan.valid && out_chan.item_kind != KIND_STATUS
    |-> out_chan.status_code == ST_OK)
  `ISO_ASSERT_NR(a_reset_empties_queue, !rst_n |=> !out_chan.valid)

endmodule
